// File: hw/rtl/irss_pkg.sv
// Shared types, constants and the microcode program of the infrared range scan sequencer.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package irss_pkg;

  localparam int unsigned RAW_W      = 10;
  localparam int unsigned RC_W       = 24;
  localparam int unsigned COS_W      = 16;
  localparam int unsigned DIST_W     = 14;
  localparam int unsigned IDX_W      = 2;
  localparam int unsigned MASK_W     = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned PC_W       = 3;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned DIVD_W     = 32;
  localparam int unsigned ROOT_W     = 16;
  localparam int unsigned SQREM_W    = 18;
  localparam int unsigned PROD_W     = 30;
  localparam int unsigned SUM_W      = 31;
  localparam int unsigned FRAC_SHIFT = 15;

  localparam logic [DIST_W-1:0] DIST_SAT             = 14'h3FFF;
  localparam logic [RC_W-1:0]   RANGE_CONSTANT_RESET = 24'd705608;
  localparam logic [COS_W-1:0]  COS_RESET            = 16'd32768;
  localparam logic [SUM_W-1:0]  ROUND_HALF           = 31'd16384;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_WAITING = 2'd1,
    PH_READING = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    REG_ENABLE         = 2'd0,
    REG_RANGE_CONSTANT = 2'd1,
    REG_FAR_COS        = 2'd2,
    REG_MID_COS        = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_DISPATCH,
    OP_DIV_STEP,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_MUL,
    OP_ROUND,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_NO_ITEM,
    COND_NO_CALC,
    COND_LOOP,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
    logic [CNT_W-1:0] count;
  } ctrl_t;

  typedef struct packed {
    logic item_taken;
    logic calc;
    logic out_busy;
  } status_t;

  localparam logic [PC_W-1:0] STEP_ACCEPT    = 3'd0;
  localparam logic [PC_W-1:0] STEP_DISPATCH  = 3'd1;
  localparam logic [PC_W-1:0] STEP_DIV       = 3'd2;
  localparam logic [PC_W-1:0] STEP_SQRT_INIT = 3'd3;
  localparam logic [PC_W-1:0] STEP_SQRT      = 3'd4;
  localparam logic [PC_W-1:0] STEP_MUL       = 3'd5;
  localparam logic [PC_W-1:0] STEP_ROUND     = 3'd6;
  localparam logic [PC_W-1:0] STEP_EMIT      = 3'd7;

  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIVD_W - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);

  // The program. The emit step sits at the last address so that the step
  // counter wraps back to the accept step on its own.
  function automatic ctrl_t ucode_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    unique case (pc)
      STEP_ACCEPT:    w = '{OP_ACCEPT,    COND_NO_ITEM,  STEP_ACCEPT, '0};
      STEP_DISPATCH:  w = '{OP_DISPATCH,  COND_NO_CALC,  STEP_EMIT,   DIV_LAST};
      STEP_DIV:       w = '{OP_DIV_STEP,  COND_LOOP,     STEP_DIV,    '0};
      STEP_SQRT_INIT: w = '{OP_SQRT_INIT, COND_NEXT,     STEP_ACCEPT, SQRT_LAST};
      STEP_SQRT:      w = '{OP_SQRT_STEP, COND_LOOP,     STEP_SQRT,   '0};
      STEP_MUL:       w = '{OP_MUL,       COND_NEXT,     STEP_ACCEPT, '0};
      STEP_ROUND:     w = '{OP_ROUND,     COND_NEXT,     STEP_ACCEPT, '0};
      STEP_EMIT:      w = '{OP_EMIT,      COND_OUT_BUSY, STEP_EMIT,   '0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/irss_sequencer.sv
// Microcode sequencer: step counter, loop counter and conditional jumps over the program ROM.
// Depends on irss_pkg for the control word, status and program.
`timescale 1ns / 1ps
`default_nettype none

module irss_sequencer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  irss_pkg::status_t    status,
  output irss_pkg::ctrl_t      ctrl
);
  import irss_pkg::*;

  logic [PC_W-1:0]  pc;
  logic [PC_W-1:0]  pc_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             take;

  assign ctrl = ucode_word(pc);

  always_comb begin
    unique case (ctrl.cond)
      COND_NEXT:     take = 1'b0;
      COND_NO_ITEM:  take = !status.item_taken;
      COND_NO_CALC:  take = !status.calc;
      COND_LOOP:     take = (cnt != '0);
      COND_OUT_BUSY: take = status.out_busy;
      default:       take = 1'b0;
    endcase
    pc_next = take ? ctrl.target : pc + 1'b1;
    // A looping word counts down; any other word loads the count for the next loop.
    if (ctrl.cond == COND_LOOP) begin
      cnt_next = (cnt != '0) ? cnt - 1'b1 : cnt;
    end else begin
      cnt_next = ctrl.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= STEP_ACCEPT;
      cnt <= '0;
    end else begin
      pc  <= pc_next;
      cnt <= cnt_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/irss_datapath.sv
// Datapath: configuration registers, scan state, shift divider, square root, cosine scaling
// and the output register. Driven by the control word of irss_sequencer; uses irss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irss_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  irss_pkg::ctrl_t                           ctrl,
  output irss_pkg::status_t                         status,
  input  wire logic                                 cfg_write,
  input  wire logic [irss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [irss_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 func,
  input  wire logic [irss_pkg::RAW_W-1:0]           raw_sample,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [irss_pkg::MASK_W-1:0]               emitter_mask,
  output logic                                      adc_start,
  output logic                                      sample_done,
  output logic [irss_pkg::IDX_W-1:0]                sensor_index,
  output logic [irss_pkg::RAW_W-1:0]                reading,
  output logic [irss_pkg::DIST_W-1:0]               distance_q4,
  output logic [irss_pkg::DIST_W-1:0]               adjusted_q4,
  output logic                                      out_of_range
);
  import irss_pkg::*;

  // Configuration.
  logic             enable;
  logic [RC_W-1:0]  range_constant;
  logic [COS_W-1:0] far_cos;
  logic [COS_W-1:0] mid_cos;

  // Scan state.
  phase_t           phase;
  phase_t           phase_next;
  logic [IDX_W-1:0] current_sensor;
  logic [IDX_W-1:0] current_sensor_next;
  logic             sample_ready;
  logic             sample_ready_next;
  logic [RAW_W-1:0] latched_sample;
  logic [RAW_W-1:0] latched_sample_next;

  // Captured transaction.
  logic             item_func;
  logic [RAW_W-1:0] item_raw;

  // Result being built.
  logic [MASK_W-1:0] res_mask;
  logic              res_adc;
  logic              res_done;
  logic [IDX_W-1:0]  res_idx;
  logic [RAW_W-1:0]  res_reading;
  logic              res_oor;
  logic [DIST_W-1:0] res_dist;
  logic [DIST_W-1:0] res_adj;

  // Arithmetic working registers.
  logic [RAW_W-1:0]   div_rem;
  logic [DIVD_W-1:0]  div_quo;
  logic [DIVD_W-1:0]  sq_val;
  logic [SQREM_W-1:0] sq_rem;
  logic [ROOT_W-1:0]  sq_root;
  logic [PROD_W-1:0]  prod;

  logic              adc_d;
  logic              calc;
  logic [MASK_W-1:0] mask_next;
  logic              item_taken;
  logic              out_busy;
  logic              emit;

  logic [RAW_W:0]       div_trial;
  logic                 div_ge;
  logic [RAW_W:0]       div_diff;
  logic [SQREM_W+1:0]   sq_shift;
  logic [SQREM_W+1:0]   sq_trial;
  logic                 sq_ge;
  logic [SQREM_W+1:0]   sq_diff;
  logic [DIST_W-1:0]    dist_sat;
  logic [COS_W-1:0]     cos_sel;
  logic [SUM_W-1:0]     round_sum;
  logic [SUM_W-FRAC_SHIFT-1:0] round_hi;

  assign in_ready   = (ctrl.op == OP_ACCEPT) && !rst;
  assign item_taken = in_valid && in_ready;
  assign out_busy   = out_valid && !out_ready;
  assign emit       = (ctrl.op == OP_EMIT) && !out_busy;

  // Scan state update of one transaction.
  always_comb begin
    phase_next          = phase;
    current_sensor_next = current_sensor;
    sample_ready_next   = sample_ready;
    latched_sample_next = latched_sample;
    adc_d               = 1'b0;
    calc                = 1'b0;
    if (ctrl.op == OP_DISPATCH) begin
      if (item_func) begin
        latched_sample_next = item_raw;
        sample_ready_next   = 1'b1;
      end else if (!enable) begin
        phase_next = PH_IDLE;
      end else begin
        unique case (phase)
          PH_WAITING: begin
            adc_d      = 1'b1;
            phase_next = PH_READING;
          end
          PH_READING: begin
            if (sample_ready) begin
              calc                = 1'b1;
              sample_ready_next   = 1'b0;
              phase_next          = PH_IDLE;
              current_sensor_next = current_sensor + 1'b1;
            end
          end
          default: phase_next = PH_WAITING;
        endcase
      end
    end
    mask_next = (phase_next == PH_WAITING || phase_next == PH_READING)
              ? (MASK_W'(1) << current_sensor_next) : '0;
  end

  assign status = '{item_taken: item_taken, calc: calc, out_busy: out_busy};

  // One restoring division step and one square root step.
  always_comb begin
    div_trial = {div_rem, div_quo[DIVD_W-1]};
    div_ge    = (div_trial >= {1'b0, res_reading});
    div_diff  = div_trial - {1'b0, res_reading};
    sq_shift  = {sq_rem, sq_val[DIVD_W-1 -: 2]};
    sq_trial  = {2'b00, sq_root, 2'b01};
    sq_ge     = (sq_shift >= sq_trial);
    sq_diff   = sq_shift - sq_trial;
  end

  // Saturation, cosine group and rounding.
  always_comb begin
    if (res_oor || (sq_root[ROOT_W-1:DIST_W] != '0)) begin
      dist_sat = DIST_SAT;
    end else begin
      dist_sat = sq_root[DIST_W-1:0];
    end
    cos_sel   = (res_idx == 2'd0 || res_idx == 2'd3) ? far_cos : mid_cos;
    round_sum = {1'b0, prod} + ROUND_HALF;
    round_hi  = round_sum[SUM_W-1:FRAC_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b0;
      range_constant <= RANGE_CONSTANT_RESET;
      far_cos        <= COS_RESET;
      mid_cos        <= COS_RESET;
      phase          <= PH_IDLE;
      current_sensor <= '0;
      sample_ready   <= 1'b0;
      latched_sample <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_ENABLE:         enable         <= cfg_data[0];
          REG_RANGE_CONSTANT: range_constant <= cfg_data[RC_W-1:0];
          REG_FAR_COS:        far_cos        <= cfg_data[COS_W-1:0];
          REG_MID_COS:        mid_cos        <= cfg_data[COS_W-1:0];
        endcase
      end
      phase          <= phase_next;
      current_sensor <= current_sensor_next;
      sample_ready   <= sample_ready_next;
      latched_sample <= latched_sample_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (item_taken) begin
      item_func <= func;
      item_raw  <= raw_sample;
    end
    unique case (ctrl.op)
      OP_DISPATCH: begin
        res_mask    <= mask_next;
        res_adc     <= adc_d;
        res_done    <= calc;
        res_idx     <= calc ? current_sensor : '0;
        res_reading <= calc ? latched_sample : '0;
        res_oor     <= calc && (latched_sample[RAW_W-1:1] == '0);
        res_dist    <= '0;
        res_adj     <= '0;
        div_rem     <= '0;
        div_quo     <= {range_constant, 8'h00};
      end
      OP_DIV_STEP: begin
        div_rem <= div_ge ? div_diff[RAW_W-1:0] : div_trial[RAW_W-1:0];
        div_quo <= {div_quo[DIVD_W-2:0], div_ge};
      end
      OP_SQRT_INIT: begin
        sq_val  <= div_quo;
        sq_rem  <= '0;
        sq_root <= '0;
      end
      OP_SQRT_STEP: begin
        sq_rem  <= sq_ge ? sq_diff[SQREM_W-1:0] : sq_shift[SQREM_W-1:0];
        sq_root <= {sq_root[ROOT_W-2:0], sq_ge};
        sq_val  <= {sq_val[DIVD_W-3:0], 2'b00};
      end
      OP_MUL: begin
        res_dist <= dist_sat;
        prod     <= PROD_W'(dist_sat) * PROD_W'(cos_sel);
      end
      OP_ROUND: begin
        res_adj <= (round_hi[SUM_W-FRAC_SHIFT-1:DIST_W] != '0) ? DIST_SAT
                 : round_hi[DIST_W-1:0];
      end
      OP_EMIT: begin
        if (emit) begin
          emitter_mask <= res_mask;
          adc_start    <= res_adc;
          sample_done  <= res_done;
          sensor_index <= res_idx;
          reading      <= res_reading;
          distance_q4  <= res_dist;
          adjusted_q4  <= res_adj;
          out_of_range <= res_oor;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/ir_range_scan_sequencer_top.sv
// Infrared range scan sequencer for four reflectance sensors.
// Input channel: in_valid/in_ready with func (0 timer tick, 1 conversion complete) and
//   raw_sample. Output channel: out_valid/out_ready, one result transaction per input
//   transaction, carrying emitter drive, converter start pulse and the computed distance.
// Configuration: cfg_write writes cfg_data to one of enable, range_constant, far_cos_q15
//   or mid_cos_q15, selected by cfg_index; write only while no transaction is in flight.
// Timing: a tick or a completion that computes nothing goes from acceptance through the
//   dispatch step to the result. A tick that computes a distance runs a 32-step shift divider
//   that forms range_constant * 256 / raw, then a 16-step digit-by-digit square root, then
//   the cosine multiply, the rounding and the loading of the output register.
//   The next transaction is accepted the cycle after the result is loaded.
// Stalls: the output register holds a finished result while out_ready is low; the block
//   may already accept and work on the next transaction, and waits in its emit step only
//   if the output register is still full when the next result is ready.
// Reset (rst, synchronous, active high): scanning disabled, phase idle, sensor 0, no
//   sample pending, calibration registers at their default values, output empty.
// The control lives in a microcode ROM walked by irss_sequencer; irss_datapath holds the
//   scan state and arithmetic.
`timescale 1ns / 1ps
`default_nettype none

module ir_range_scan_sequencer_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [irss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [irss_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               func,
  input  wire logic [irss_pkg::RAW_W-1:0]         raw_sample,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [irss_pkg::MASK_W-1:0]             emitter_mask,
  output logic                                    adc_start,
  output logic                                    sample_done,
  output logic [irss_pkg::IDX_W-1:0]              sensor_index,
  output logic [irss_pkg::RAW_W-1:0]              reading,
  output logic [irss_pkg::DIST_W-1:0]             distance_q4,
  output logic [irss_pkg::DIST_W-1:0]             adjusted_q4,
  output logic                                    out_of_range
);
  import irss_pkg::*;

  // The control word selects one datapath operation per cycle; the status returned
  // tells the sequencer whether a transaction was taken, whether a distance must be
  // computed and whether the output register is still occupied.
  ctrl_t   ctrl;
  status_t status;

  irss_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  irss_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .raw_sample   (raw_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .emitter_mask (emitter_mask),
    .adc_start    (adc_start),
    .sample_done  (sample_done),
    .sensor_index (sensor_index),
    .reading      (reading),
    .distance_q4  (distance_q4),
    .adjusted_q4  (adjusted_q4),
    .out_of_range (out_of_range)
  );

endmodule

`default_nettype wire

// File: hw/rtl/irss_checker.sv
// Port-level checker for the infrared range scan sequencer and its bind to the top level.
// Depends on irss_pkg for widths only.
`timescale 1ns / 1ps
`default_nettype none

module irss_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [irss_pkg::MASK_W-1:0]     emitter_mask,
  input wire logic                            adc_start,
  input wire logic                            sample_done,
  input wire logic [irss_pkg::IDX_W-1:0]      sensor_index,
  input wire logic [irss_pkg::RAW_W-1:0]      reading,
  input wire logic [irss_pkg::DIST_W-1:0]     distance_q4,
  input wire logic [irss_pkg::DIST_W-1:0]     adjusted_q4,
  input wire logic                            out_of_range
);

  // A stalled result transaction keeps its distance fields.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance_q4) && $stable(adjusted_q4))
    else $error("result changed while stalled");

  // Without a computed distance the distance, reading, sensor index and out of range fields read zero.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sample_done |-> distance_q4 == '0 && adjusted_q4 == '0 && reading == '0
      && sensor_index == '0 && !out_of_range)
    else $error("distance fields set without a computed distance");

  // An out of range sample always saturates the distance.
  a_saturate: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> sample_done && distance_q4 == 14'h3FFF && reading <= 10'd1)
    else $error("out of range sample not saturated");

  // At most one emitter is lit, and it is lit when a conversion is requested.
  a_emitter: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(emitter_mask) && (!adc_start || emitter_mask != '0))
    else $error("emitter drive inconsistent");

  // A computed distance switches the emitter off and requests no conversion.
  a_done_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_done |-> emitter_mask == '0 && !adc_start)
    else $error("emitter left on after a computed distance");

endmodule

bind ir_range_scan_sequencer_top irss_checker u_irss_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .emitter_mask (emitter_mask),
  .adc_start    (adc_start),
  .sample_done  (sample_done),
  .sensor_index (sensor_index),
  .reading      (reading),
  .distance_q4  (distance_q4),
  .adjusted_q4  (adjusted_q4),
  .out_of_range (out_of_range)
);

`default_nettype wire
